>>> design/bsc_pkg.sv
// Shared types and constants for the bright spot counter.
// No dependencies; bright_spot_counter and bsc_star_logic import this package.
package bsc_pkg;

    localparam int DEFAULT_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int COUNT_W           = 25;
    localparam int DIM_W             = 13;
    localparam int ROW_W             = 12;
    localparam int CHAN_W            = 8;
    localparam int STARS_W           = 3;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 13;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(25'd16777216);

    localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RESET     = 13'd640;
    localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RESET    = 13'd480;
    localparam logic [CHAN_W-1:0] WHITE_THRESHOLD_RESET = 8'd200;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_WHITE_THRESHOLD = 2'd2
    } bsc_reg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } bsc_pixel_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pixels_seen;
        logic [COUNT_W-1:0] white_count;
        logic [COUNT_W-1:0] star_count;
        logic               frame_done;
    } bsc_result_t;

    // Sliding window of white bits around the current pixel.
    typedef struct packed {
        logic up1;   // previous row, x-1
        logic cur2;  // current row, x-2
        logic cur1;  // current row, x-1
    } bsc_window_t;

    // Per-pixel decision handed from the star logic to the top level.
    typedef struct packed {
        logic               white;
        logic               up;
        logic               last_col;
        logic               last_row;
        logic [STARS_W-1:0] stars;
    } bsc_eval_t;

endpackage

>>> design/bright_spot_counter.sv
// Top level of the bright spot counter: configuration, frame state, counters, result register.
// Depends on bsc_pkg, bsc_line_buffer and bsc_star_logic.
//
// The block takes one RGB pixel request per cycle in raster order and returns one result per
// pixel, in the cycle after it is accepted: the running pixel, white and star counts of the
// frame and a frame_done mark on the last pixel. Throughput is one pixel per clock; the
// result register stands between the two channels, so a new pixel is taken whenever that
// register is empty or is being drained in the same cycle. Each pixel needs one line-buffer
// access: the pixel above's white bit is read ahead, registered, at the next column, with the
// bit just written forwarded when both hit the same column. Counters saturate at 2**24 and
// clear after the frame_done result. The line buffer is not cleared; the first row of a frame
// never reads it. Write image_width, image_height and white_threshold only while the block is
// idle; a smaller width or height takes effect at once and ends the row or frame there.
module bright_spot_counter #(
    parameter int MAX_WIDTH = bsc_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bsc_pkg::bsc_pixel_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bsc_pkg::bsc_result_t            out_data,
    input  logic                            cfg_write,
    input  logic [bsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Configuration registers.
    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;
    logic [CHAN_W-1:0] white_threshold_reg;

    // Frame state.
    logic [COL_W-1:0]   col_reg,       col_next;
    logic [ROW_W-1:0]   row_reg,       row_next;
    bsc_window_t        win_reg,       win_next;
    logic [COUNT_W-1:0] pix_cnt_reg,   pix_cnt_next;
    logic [COUNT_W-1:0] white_cnt_reg, white_cnt_next;
    logic [COUNT_W-1:0] star_cnt_reg,  star_cnt_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    bsc_result_t out_data_reg,  out_data_next;

    logic               accept;
    logic               up_raw;
    bsc_eval_t          eval;
    logic [COUNT_W-1:0] pix_sum;
    logic [COUNT_W-1:0] white_sum;
    logic [COUNT_W-1:0] star_sum;
    logic [COUNT_W-1:0] pix_sat;
    logic [COUNT_W-1:0] white_sat;
    logic [COUNT_W-1:0] star_sat;
    logic               done;

    // Take a new request whenever the result register frees up this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg     <= IMAGE_WIDTH_RESET;
            image_height_reg    <= IMAGE_HEIGHT_RESET;
            white_threshold_reg <= WHITE_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:     image_width_reg     <= cfg_data;
                REG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data;
                REG_WHITE_THRESHOLD: white_threshold_reg <= cfg_data[CHAN_W-1:0];
                default:             ; // unmapped index: drop the write
            endcase
        end
    end

    bsc_star_logic #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_star_logic (
        .pixel        (in_data),
        .threshold    (white_threshold_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .col          (col_reg),
        .row          (row_reg),
        .window       (win_reg),
        .up_raw       (up_raw),
        .eval         (eval)
    );

    // Read ahead at the column the next pixel will use.
    bsc_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (eval.white),
        .rd_addr (col_next),
        .rd_data (up_raw)
    );

    // Saturating counters: the sum never exceeds 2**24 + 4, so 25 bits hold it.
    assign pix_sum   = pix_cnt_reg + COUNT_W'(1);
    assign white_sum = white_cnt_reg + COUNT_W'(eval.white);
    assign star_sum  = star_cnt_reg + COUNT_W'(eval.stars);
    assign pix_sat   = (pix_sum   > COUNT_LIMIT) ? COUNT_LIMIT : pix_sum;
    assign white_sat = (white_sum > COUNT_LIMIT) ? COUNT_LIMIT : white_sum;
    assign star_sat  = (star_sum  > COUNT_LIMIT) ? COUNT_LIMIT : star_sum;
    assign done      = eval.last_col && eval.last_row;

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        win_next       = win_reg;
        pix_cnt_next   = pix_cnt_reg;
        white_cnt_next = white_cnt_reg;
        star_cnt_next  = star_cnt_reg;
        if (accept)
        begin
            if (eval.last_col)
            begin
                col_next = '0;
                win_next = '0;
                // Wrap the row at the frame end, advance it otherwise.
                row_next = eval.last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next      = col_reg + COL_W'(1);
                win_next.cur1 = eval.white;
                win_next.cur2 = win_reg.cur1;
                win_next.up1  = eval.up;
            end
            if (done)
            begin
                pix_cnt_next   = '0;
                white_cnt_next = '0;
                star_cnt_next  = '0;
            end
            else
            begin
                pix_cnt_next   = pix_sat;
                white_cnt_next = white_sat;
                star_cnt_next  = star_sat;
            end
        end
    end

    // Load the result on accept, drop it once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next           = 1'b1;
            out_data_next.pixels_seen = pix_sat;
            out_data_next.white_count = white_sat;
            out_data_next.star_count  = star_sat;
            out_data_next.frame_done  = done;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            win_reg       <= '0;
            pix_cnt_reg   <= '0;
            white_cnt_reg <= '0;
            star_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            win_reg       <= win_next;
            pix_cnt_reg   <= pix_cnt_next;
            white_cnt_reg <= white_cnt_next;
            star_cnt_reg  <= star_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/bsc_line_buffer.sv
// One-row line buffer of white bits, one write and one registered read per cycle.
// Depends on nothing but its parameter; read-during-write returns the new bit.
module bsc_line_buffer #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic                         wr_data,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic                         rd_data
);
    logic mem [MAX_WIDTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Forward the bit being written when the next read hits the same column.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/bsc_star_logic.sv
// Combinational classification of one pixel: white test, row/column ends, stars resolved.
// Depends on bsc_pkg for the pixel, window and decision types.
module bsc_star_logic #(
    parameter int MAX_WIDTH = 4096
) (
    input  bsc_pkg::bsc_pixel_t              pixel,
    input  logic [bsc_pkg::CHAN_W-1:0]       threshold,
    input  logic [bsc_pkg::DIM_W-1:0]        image_width,
    input  logic [bsc_pkg::DIM_W-1:0]        image_height,
    input  logic [$clog2(MAX_WIDTH)-1:0]     col,
    input  logic [bsc_pkg::ROW_W-1:0]        row,
    input  bsc_pkg::bsc_window_t             window,
    input  logic                             up_raw,
    output bsc_pkg::bsc_eval_t               eval
);
    import bsc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W > DIM_W) ? COL_W : DIM_W;

    logic             white;
    logic             has_above;
    logic             up;
    logic [CMP_W-1:0] width_m1;
    logic [DIM_W-1:0] height_m1;
    logic             last_col;
    logic             last_row;
    logic             s_up_left;
    logic             s_up_end;
    logic             s_left;
    logic             s_end;

    assign white = (pixel.red > threshold) && (pixel.green > threshold)
                && (pixel.blue > threshold);

    // Clamp the width into 1..MAX_WIDTH and the height into 1..MAX_HEIGHT.
    always_comb
    begin
        if (image_width == '0)
        begin
            width_m1 = '0;
        end
        else if (32'(image_width) > 32'(MAX_WIDTH))
        begin
            width_m1 = CMP_W'(MAX_WIDTH - 1);
        end
        else
        begin
            width_m1 = CMP_W'(image_width) - CMP_W'(1);
        end
    end

    always_comb
    begin
        if (image_height == '0)
        begin
            height_m1 = '0;
        end
        else if (32'(image_height) > 32'(MAX_HEIGHT))
        begin
            height_m1 = DIM_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            height_m1 = image_height - DIM_W'(1);
        end
    end

    assign last_col  = CMP_W'(col) >= width_m1;
    assign last_row  = DIM_W'(row) >= height_m1;
    assign has_above = (row != '0);
    assign up        = has_above && up_raw;

    // Previous-row pixel at x-1, resolved by its diagonal neighbor below-right.
    assign s_up_left = has_above && window.up1 && !up && !window.cur2 && !window.cur1 && !white;
    // Previous-row pixel at x, resolved at the end of the row.
    assign s_up_end  = has_above && last_col && up && !window.cur1 && !white;
    // Last row: nothing below, resolve at once.
    assign s_left    = last_row && window.cur1 && !white;
    assign s_end     = last_row && last_col && white;

    always_comb
    begin
        eval.white    = white;
        eval.up       = up;
        eval.last_col = last_col;
        eval.last_row = last_row;
        eval.stars    = STARS_W'(s_up_left) + STARS_W'(s_up_end)
                      + STARS_W'(s_left) + STARS_W'(s_end);
    end

endmodule

>>> bench/tb.sv
// Self-checking testbench for bright_spot_counter. It drives pixel frames, directed and random,
// and checks every result field by field against a built-in count predictor.
// Depends on bsc_pkg and the design sources under design/.
`timescale 1ns / 100ps

module tb;
    import bsc_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int RUN_LIMIT_NS   = 4_000_000;
    localparam int MAX_COLS       = DEFAULT_MAX_WIDTH;
    localparam int RANDOM_PIXELS  = 1400;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PERCENT   = 30;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_RUN       = 40;

    // Index past the last register; writes to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    bsc_pixel_t             in_data;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    bsc_result_t            out_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of the registers.
    logic [DIM_W-1:0]  width_reg  = IMAGE_WIDTH_RESET;
    logic [DIM_W-1:0]  height_reg = IMAGE_HEIGHT_RESET;
    logic [CHAN_W-1:0] thresh_reg = WHITE_THRESHOLD_RESET;

    // Predictor copy of the frame state.
    bit          line_white [MAX_COLS];
    int unsigned col_pos     = 0;
    int unsigned row_pos     = 0;
    bsc_window_t win         = '0;
    int unsigned px_total    = 0;
    int unsigned white_total = 0;
    int unsigned star_total  = 0;

    bsc_result_t expected_counts [$];
    int unsigned mismatch_total = 0;
    int unsigned pixels_sent    = 0;
    bit          frame_ended    = 1'b0;
    bit          gaps_on        = 1'b1;

    always #HALF_PERIOD clk = ~clk;

    bright_spot_counter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Count predictor
    // ------------------------------------------------------------------

    // Zero acts as one, anything past the line buffer acts as its size.
    function automatic int unsigned eff_width();
        int unsigned w;
        w = (width_reg == 0) ? 1 : width_reg;
        return (w > MAX_COLS) ? MAX_COLS : w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = (height_reg == 0) ? 1 : height_reg;
        return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    endfunction

    function automatic int unsigned saturate(input int unsigned value);
        return (value > COUNT_LIMIT) ? COUNT_LIMIT : value;
    endfunction

    // Advance the frame state by one pixel and return the counts it should produce.
    function automatic bsc_result_t count_pixel(input bsc_pixel_t px);
        int unsigned w, h, x, stars;
        bit          is_white, above, last_col, last_row;
        bsc_result_t res;
        w        = eff_width();
        h        = eff_height();
        is_white = (px.red > thresh_reg) && (px.green > thresh_reg) && (px.blue > thresh_reg);
        x        = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        above    = 1'b0;
        stars    = 0;
        // Resolve the row above: its pixel at x-1 once the lower-right neighbor is known,
        // its pixel at x when this is the end of the row.
        if (row_pos > 0)
        begin
            above = line_white[x];
            if (win.up1 && !above && !win.cur2 && !win.cur1 && !is_white)
                stars++;
            if (last_col && above && !win.cur1 && !is_white)
                stars++;
        end
        // Nothing lies below the last row: resolve its pixels right away.
        if (last_row)
        begin
            if (win.cur1 && !is_white)
                stars++;
            if (last_col && is_white)
                stars++;
        end
        line_white[x] = is_white;

        px_total    = saturate(px_total + 1);
        white_total = saturate(white_total + is_white);
        star_total  = saturate(star_total + stars);

        res.pixels_seen = COUNT_W'(px_total);
        res.white_count = COUNT_W'(white_total);
        res.star_count  = COUNT_W'(star_total);
        res.frame_done  = last_col && last_row;

        if (last_col)
        begin
            win     = '0;
            col_pos = 0;
            if (last_row)
            begin
                row_pos     = 0;
                px_total    = 0;
                white_total = 0;
                star_total  = 0;
            end
            else
                row_pos++;
        end
        else
        begin
            win = {above, win.cur1, is_white};
            col_pos++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Pixel generation
    // ------------------------------------------------------------------

    // Build a pixel that is white or dark under the current threshold; with the
    // threshold at its top no pixel can be white, so return any pixel then.
    function automatic bsc_pixel_t make_pixel(input bit want_white);
        bsc_pixel_t px;
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        if (want_white && thresh_reg != 8'hFF)
        begin
            px.red   = 8'($urandom_range(255, thresh_reg + 1));
            px.green = 8'($urandom_range(255, thresh_reg + 1));
            px.blue  = 8'($urandom_range(255, thresh_reg + 1));
        end
        else if (!want_white)
        begin
            // Pull one channel down to the threshold or below.
            case ($urandom_range(2))
                0:       px.red   = 8'($urandom_range(thresh_reg));
                1:       px.green = 8'($urandom_range(thresh_reg));
                default: px.blue  = 8'($urandom_range(thresh_reg));
            endcase
        end
        return px;
    endfunction

    // Mostly biased pixels, with some raw noise mixed in.
    function automatic bsc_pixel_t random_pixel(input int unsigned white_pct);
        bsc_pixel_t px;
        if ($urandom_range(9) == 0)
        begin
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
            return px;
        end
        return make_pixel($urandom_range(99) < white_pct);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one pixel request, hold it until accepted, then record its expected counts.
    // Valid stays high afterwards so back-to-back requests need no extra edge.
    task automatic send_pixel(input bsc_pixel_t px);
        bsc_result_t res;
        cfg_write <= 1'b0;
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = count_pixel(px);
        expected_counts.insert(expected_counts.size(), res);
        frame_ended = res.frame_done;
        pixels_sent++;
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; the enable is held until the next pixel drops it,
    // so that back-to-back writes never lower and raise it in one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        case (index)
            REG_IMAGE_WIDTH:     width_reg  = DIM_W'(value);
            REG_IMAGE_HEIGHT:    height_reg = DIM_W'(value);
            REG_WHITE_THRESHOLD: thresh_reg = CHAN_W'(value);
            default: ;
        endcase
    endtask

    // Call only on a frame boundary: a wider row must start on row 0.
    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned thr);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_WHITE_THRESHOLD, thr);
    endtask

    // Send random pixels until the predictor marks the end of the frame.
    task automatic send_frame(input int unsigned white_pct);
        frame_ended = 1'b0;
        while (!frame_ended)
            send_pixel(random_pixel(white_pct));
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] want,
                                   input logic [COUNT_W-1:0] got);
        mismatch_total++;
        if (mismatch_total <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // Compare each accepted result with the oldest expectation, then pick the
    // next cycle's ready: random while gaps are on, steady otherwise.
    always @(posedge clk)
    begin : check_results
        bsc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
                report_mismatch("unrequested result, pixels_seen", '0, out_data.pixels_seen);
            else
            begin
                want = expected_counts.pop_front();
                if (out_data.pixels_seen !== want.pixels_seen)
                    report_mismatch("pixels_seen", want.pixels_seen, out_data.pixels_seen);
                if (out_data.white_count !== want.white_count)
                    report_mismatch("white_count", want.white_count, out_data.white_count);
                if (out_data.star_count !== want.star_count)
                    report_mismatch("star_count", want.star_count, out_data.star_count);
                if (out_data.frame_done !== want.frame_done)
                    report_mismatch("frame_done", COUNT_W'(want.frame_done),
                                    COUNT_W'(out_data.frame_done));
            end
        end
        out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 640 wide, 480 high, threshold 200. Probe the threshold from both
    // sides, then shrink width and height under the open frame so it closes at once.
    task automatic test_reset_values();
        send_pixel({8'd201, 8'd201, 8'd201});
        send_pixel({8'd200, 8'd255, 8'd255});
        send_pixel({8'd255, 8'd200, 8'd255});
        send_pixel({8'd255, 8'd255, 8'd200});
        send_pixel({8'd255, 8'd255, 8'd255});
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 6);
        write_reg(REG_IMAGE_HEIGHT, 1);
        send_pixel({8'd0, 8'd0, 8'd0});
    endtask

    // Threshold at both ends: at zero a pixel with every channel nonzero is white, at 255 none is.
    task automatic test_threshold_edges();
        configure(3, 2, 0);
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd1, 8'd1, 8'd1});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd255, 8'd0, 8'd255});
        send_pixel({8'd1, 8'd255, 8'd1});
        send_pixel({8'd255, 8'd255, 8'd0});
        configure(2, 1, 255);
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd64, 8'd32});
    endtask

    // Hand-drawn 4x3 frame: an isolated star in a corner, a star masked by a pixel
    // below, a horizontal pair, and stars resolved on the last row and last column.
    //   1 0 0 1
    //   0 0 1 0
    //   1 1 0 1
    task automatic test_star_shapes();
        logic [11:0] picture;
        picture = 12'b1001_0010_1101;
        configure(4, 3, 128);
        for (int i = 11; i >= 0; i--)
            send_pixel(make_pixel(picture[i]));
    endtask

    // Zero width and height act as one: every pixel is a frame of its own.
    task automatic test_size_clamps();
        configure(0, 0, 100);
        send_pixel(make_pixel(1'b1));
        send_pixel(make_pixel(1'b0));
    endtask

    // Registers written in the middle of a frame take effect at once: an oversized
    // height is cut back so the current row becomes the last, the width shrinks
    // to end the row at the running column, and the threshold moves.
    task automatic test_midframe_writes();
        configure(3, 8191, 60);
        repeat (4)
            send_pixel(random_pixel(50));
        wait_drained();
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_WHITE_THRESHOLD, 180);
        write_reg(REG_IMAGE_WIDTH, 2);
        send_pixel(random_pixel(50));
    endtask

    // A write to the index past the last register changes nothing.
    task automatic test_unused_register();
        configure(5, 1, 90);
        write_reg(REG_UNUSED, 13'h1FFF);
        send_frame(50);
    endtask

    // Oversized width and height act as 4096: run a stretch of one row under an
    // oversized width, and of one column under an oversized height, then cut the
    // size back so each frame closes on the next pixel.
    task automatic test_largest_frames();
        configure(8191, 8191, 140);
        repeat (LONG_RUN)
            send_pixel(random_pixel(30));
        wait_drained();
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_reg(REG_IMAGE_WIDTH, LONG_RUN + 1);
        send_pixel(random_pixel(30));
        configure(1, 8191, 140);
        repeat (LONG_RUN)
            send_pixel(random_pixel(30));
        wait_drained();
        write_reg(REG_IMAGE_HEIGHT, LONG_RUN + 1);
        send_pixel(random_pixel(30));
    endtask

    // Random frames, mostly small, with random thresholds and white density. Some
    // frames are interrupted midway to cut height or width and move the threshold;
    // width never grows mid-frame, so no unwritten line buffer entry is read.
    task automatic test_random_frames();
        int unsigned first_pixel, w_set, h_set, thr, pct, cut;
        first_pixel = pixels_sent;
        while (pixels_sent - first_pixel < RANDOM_PIXELS)
        begin
            // Hold both sides busy for a long stretch in the middle.
            gaps_on = !(pixels_sent - first_pixel >= 500 && pixels_sent - first_pixel < 900);
            case ($urandom_range(19))
                0:          w_set = 0;
                1, 2, 3:    w_set = $urandom_range(40, 13);
                default:    w_set = $urandom_range(12, 1);
            endcase
            case ($urandom_range(19))
                0:          h_set = 0;
                1, 2:       h_set = $urandom_range(16, 9);
                default:    h_set = $urandom_range(8, 1);
            endcase
            case ($urandom_range(9))
                0:          thr = 0;
                1:          thr = 255;
                default:    thr = $urandom_range(255);
            endcase
            pct = $urandom_range(95, 5);
            configure(w_set, h_set, thr);
            if ($urandom_range(4) == 0 && eff_width() * eff_height() > 1)
            begin
                cut = $urandom_range(eff_width() * eff_height() - 1, 1);
                repeat (cut)
                    send_pixel(random_pixel(pct));
                wait_drained();
                write_reg(REG_IMAGE_HEIGHT, $urandom_range(eff_height()));
                write_reg(REG_WHITE_THRESHOLD, $urandom_range(255));
                if ($urandom_range(1))
                    write_reg(REG_IMAGE_WIDTH, $urandom_range(eff_width()));
            end
            send_frame(pct);
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (line_white[i])
            line_white[i] = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_threshold_edges();
        test_star_shapes();
        test_size_clamps();
        test_midframe_writes();
        test_unused_register();
        test_largest_frames();
        test_random_frames();

        // Drain, then leave room for any stray result to show up.
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_total == 0)
            $display("bright_spot_counter test passed");
        else
            $display("bright_spot_counter test failed");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("bright_spot_counter test failed");
        $finish;
    end

endmodule

>>> files.f
design/bsc_pkg.sv
design/bsc_line_buffer.sv
design/bsc_star_logic.sv
design/bright_spot_counter.sv
bench/tb.sv
